// ===== src/rsid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsid_pkg
// Shared constants, types and GF(16) arithmetic for the RS(15,3) ID encoder.
// ----------------------------------------------------------------------------
package rsid_pkg;

    localparam int NUM_SYMBOLS = 15;
    localparam int NUM_ROOTS   = 12;
    localparam int SYM_W       = 4;
    localparam int IDX_W       = 4;
    localparam int CODE_W      = 12;
    localparam int ROUND_W     = $clog2(NUM_ROOTS);

    // x^4 + x^3 + 1
    localparam logic [SYM_W:0] GF_POLY = 5'h19;

    localparam logic [SYM_W-1:0] ROOTS [NUM_ROOTS] = '{
        4'd2, 4'd4, 4'd8, 4'd9, 4'd11, 4'd15, 4'd7, 4'd14, 4'd5, 4'd10, 4'd13, 4'd3
    };

    typedef logic [NUM_SYMBOLS-1:0][SYM_W-1:0] t_word;

    typedef enum logic [1:0] {
        CORE_EMPTY,
        CORE_RUN,
        CORE_FULL
    } t_core_state;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [SYM_W-1:0] root;
    } t_cell_ctl;

    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b);
        logic [SYM_W-1:0] acc;
        logic [SYM_W:0]   x;
        acc = '0;
        x   = {1'b0, a};
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = {x[SYM_W-1:0], 1'b0};
            if (x[SYM_W]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

// ===== src/rsid_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsid_cell
// One symbol of the code word register: per round, multiply own symbol by
// the current root and add the lower neighbor's old symbol.
// ----------------------------------------------------------------------------
module rsid_cell (
    input  wire logic                       i_clk,
    input  wire rsid_pkg::t_cell_ctl        i_ctl,
    input  wire logic [rsid_pkg::SYM_W-1:0] i_load_sym,
    input  wire logic [rsid_pkg::SYM_W-1:0] i_prev_sym,
    output logic      [rsid_pkg::SYM_W-1:0] o_sym
);

    logic [rsid_pkg::SYM_W-1:0] r_sym;
    logic [rsid_pkg::SYM_W-1:0] n_sym;

    always_comb begin
        n_sym = r_sym;
        if (i_ctl.load) begin
            n_sym = i_load_sym;
        end else if (i_ctl.step) begin
            n_sym = i_prev_sym ^ rsid_pkg::gf_mul(r_sym, i_ctl.root);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    assign o_sym = r_sym;

endmodule
`default_nettype wire

// ===== src/rsid_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsid_serializer
// Output shift line: takes a finished code word in parallel and sends it
// one symbol per word, index 0 first.
// ----------------------------------------------------------------------------
module rsid_serializer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire rsid_pkg::t_word            i_word,
    output logic                            o_ready,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [rsid_pkg::SYM_W-1:0]      o_symbol,
    output logic [rsid_pkg::IDX_W-1:0]      o_index,
    output logic                            o_tlast
);

    rsid_pkg::t_word             r_buf;
    logic                        r_valid;
    logic [rsid_pkg::IDX_W-1:0]  r_cnt;
    logic                        w_last;
    logic                        w_take;

    assign w_last  = (r_cnt == rsid_pkg::IDX_W'(rsid_pkg::NUM_SYMBOLS - 1));
    assign w_take  = r_valid && i_tready;
    assign o_ready = !r_valid || (w_take && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (w_take) begin
            r_valid <= !w_last;
            r_cnt   <= w_last ? '0 : r_cnt + 1'b1;
        end
    end

    // advance the shift line toward symbol 0 on every taken word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_word;
        end else if (w_take) begin
            for (int k = 0; k < rsid_pkg::NUM_SYMBOLS - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_symbol = r_buf[0];
    assign o_index  = r_cnt;
    assign o_tlast  = w_last;

endmodule
`default_nettype wire

// ===== src/rs_gf16_id_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rs_gf16_id_encoder
// Reed-Solomon (15,3) encoder over GF(16) for a 12-bit identifier code.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word carries a 12-bit code in tdata[11:0].
//   Master channel: fifteen words per code, tdata[3:0] the symbol,
//   tdata[7:4] its index (0 first), tlast on index 14.
//   A row of fifteen symbol cells runs the twelve root rounds, one round
//   per cycle, all cells in parallel; the finished word moves into an
//   output shift line that sends one symbol per cycle while tready is high.
//   The first symbol is valid once the rounds end and the word is handed off.
//   Codes are paced by the one-symbol output channel; the cell row takes
//   the next code while the previous word is still being sent.
//   Reset empties the cell row and the shift line; nothing else is kept.
//   When the receiver stalls, the shift line holds its symbol, a finished
//   word waits in the cell row, and tready falls until the line frees up.
// ----------------------------------------------------------------------------
module rs_gf16_id_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [11:0] code, [15:12] zero
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [3:0] symbol, [7:4] symbol_index
    output logic             o_m_axis_tlast
);

    rsid_pkg::t_core_state           r_state;
    rsid_pkg::t_core_state           n_state;
    logic [rsid_pkg::ROUND_W-1:0]    r_round;
    logic [rsid_pkg::ROUND_W-1:0]    n_round;
    logic                            w_accept;
    logic                            w_handoff;
    logic                            w_ser_ready;
    rsid_pkg::t_cell_ctl             w_ctl;
    rsid_pkg::t_word                 w_load;
    rsid_pkg::t_word                 w_word;
    logic [rsid_pkg::SYM_W-1:0]      w_symbol;
    logic [rsid_pkg::IDX_W-1:0]      w_index;

    assign w_handoff       = (r_state == rsid_pkg::CORE_FULL) && w_ser_ready;
    assign o_s_axis_tready = (r_state == rsid_pkg::CORE_EMPTY) || w_handoff;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsid_pkg::CORE_EMPTY;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        unique case (r_state)
            rsid_pkg::CORE_EMPTY: begin
                if (w_accept) begin
                    n_state = rsid_pkg::CORE_RUN;
                    n_round = '0;
                end
            end
            rsid_pkg::CORE_RUN: begin
                if (r_round == rsid_pkg::ROUND_W'(rsid_pkg::NUM_ROOTS - 1)) begin
                    n_state = rsid_pkg::CORE_FULL;
                    n_round = '0;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            rsid_pkg::CORE_FULL: begin
                if (w_accept) begin
                    n_state = rsid_pkg::CORE_RUN;
                    n_round = '0;
                end else if (w_handoff) begin
                    n_state = rsid_pkg::CORE_EMPTY;
                end
            end
            default: begin
                n_state = rsid_pkg::CORE_EMPTY;
                n_round = '0;
            end
        endcase
    end

    assign w_ctl.load = w_accept;
    assign w_ctl.step = (r_state == rsid_pkg::CORE_RUN);
    assign w_ctl.root = rsid_pkg::ROOTS[r_round];

    // high nibble first into the three lowest cells, the rest start at zero
    always_comb begin
        w_load    = '0;
        w_load[0] = i_s_axis_tdata[11:8];
        w_load[1] = i_s_axis_tdata[7:4];
        w_load[2] = i_s_axis_tdata[3:0];
    end

    for (genvar g = 0; g < rsid_pkg::NUM_SYMBOLS; g++) begin : g_cell
        logic [rsid_pkg::SYM_W-1:0] w_prev;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = w_word[g-1];
        end
        rsid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load_sym (w_load[g]),
            .i_prev_sym (w_prev),
            .o_sym      (w_word[g])
        );
    end

    rsid_serializer u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_handoff),
        .i_word   (w_word),
        .o_ready  (w_ser_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_symbol (w_symbol),
        .o_index  (w_index),
        .o_tlast  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_index, w_symbol};

`ifndef SYNTH
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsid_pkg::CORE_RUN) |->
            (r_round < rsid_pkg::ROUND_W'(rsid_pkg::NUM_ROOTS)))
        else $error("round counter out of range");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=>
            (r_state == rsid_pkg::CORE_RUN) && (r_round == '0))
        else $error("accepted code did not start the rounds");

    a_handoff_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_handoff |=> o_m_axis_tvalid && (o_m_axis_tdata[7:4] == '0))
        else $error("handed-off word does not start at symbol 0");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata[7:4] == rsid_pkg::IDX_W'(rsid_pkg::NUM_SYMBOLS - 1)))
        else $error("tlast not on the final symbol");
`endif

endmodule
`default_nettype wire

// ===== sim/rs_gf16_id_encoder_test.sv =====
// ----------------------------------------------------------------------------
// rs_gf16_id_encoder_test
// Self-checking bench for the RS(15,3) GF(16) ID encoder: offers 12-bit codes
// in random bursts, stalls the symbol stream on a shifting pattern plus one
// long hold-off, and checks each symbol, index and tlast against a local
// encoder that runs the twelve root rounds per code.
// ----------------------------------------------------------------------------
module rs_gf16_id_encoder_test;

    localparam int NUM_SYMBOLS = rsid_pkg::NUM_SYMBOLS;
    localparam int SYM_W       = rsid_pkg::SYM_W;
    localparam int IDX_W       = rsid_pkg::IDX_W;
    localparam int CODE_W      = rsid_pkg::CODE_W;

    localparam int ROUND_COUNT  = 12;
    localparam int RANDOM_CODES = 330;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_PRINTS   = 30;

    localparam logic [SYM_W-1:0] ROUND_ROOT [ROUND_COUNT] = '{
        4'd2, 4'd4, 4'd8, 4'd9, 4'd11, 4'd15, 4'd7, 4'd14, 4'd5, 4'd10, 4'd13, 4'd3
    };

    // directed rows: {all-zero word known, code}
    localparam int NUM_DIRECTED = 20;
    localparam logic [CODE_W:0] DIRECTED [NUM_DIRECTED] = '{
        {1'b1, 12'h000}, {1'b0, 12'hfff}, {1'b0, 12'h001}, {1'b0, 12'h002},
        {1'b0, 12'h004}, {1'b0, 12'h008}, {1'b0, 12'h010}, {1'b0, 12'h080},
        {1'b0, 12'h100}, {1'b0, 12'h800}, {1'b0, 12'h00f}, {1'b0, 12'h0f0},
        {1'b0, 12'hf00}, {1'b0, 12'haaa}, {1'b0, 12'h555}, {1'b0, 12'h123},
        {1'b0, 12'hfed}, {1'b0, 12'h7ff}, {1'b1, 12'h000}, {1'b0, 12'hffe}
    };

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_symbol_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;      // [11:0] code, [15:12] zero
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;           // [3:0] symbol, [7:4] symbol_index
    wire         m_tlast;

    t_symbol_exp symbol_q [$];
    logic        s_zero_word = 1'b0;
    int          codes_in = 0;
    int          symbols_out = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    bit          hold_done = 1'b0;

    rs_gf16_id_encoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("rs_gf16_id_encoder regression: fail");
        $finish;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    // multiply in GF(16), reducing x^4 to x^3 + 1
    function automatic logic [SYM_W-1:0] gf16_times(input logic [SYM_W-1:0] a,
                                                    input logic [SYM_W-1:0] b);
        logic [SYM_W-1:0] prod;
        logic [SYM_W-1:0] shifted;
        prod    = '0;
        shifted = a;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                prod ^= shifted;
            end
            shifted = shifted[SYM_W-1] ? ({shifted[SYM_W-2:0], 1'b0} ^ 4'h9)
                                       : {shifted[SYM_W-2:0], 1'b0};
        end
        return prod;
    endfunction

    function automatic void queue_code_word(input logic [CODE_W-1:0] code);
        logic [SYM_W-1:0] cw [NUM_SYMBOLS];
        t_symbol_exp      e;
        for (int j = 0; j < NUM_SYMBOLS; j++) begin
            cw[j] = '0;
        end
        cw[0] = code[11:8];
        cw[1] = code[7:4];
        cw[2] = code[3:0];
        // multiply the word polynomial by (x + root) once per round
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int j = NUM_SYMBOLS - 1; j > 0; j--) begin
                cw[j] = cw[j-1] ^ gf16_times(cw[j], ROUND_ROOT[r]);
            end
            cw[0] = gf16_times(cw[0], ROUND_ROOT[r]);
        end
        for (int j = 0; j < NUM_SYMBOLS; j++) begin
            e.symbol = cw[j];
            e.index  = IDX_W'(j);
            e.last   = (j == NUM_SYMBOLS - 1);
            symbol_q.push_back(e);
        end
    endfunction

    // track both channels at the rising edge
    always @(posedge i_clk) begin
        t_symbol_exp e;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                codes_in++;
                if (s_zero_word) begin
                    for (int j = 0; j < NUM_SYMBOLS; j++) begin
                        symbol_q.push_back('{symbol: '0, index: IDX_W'(j),
                                             last: (j == NUM_SYMBOLS - 1)});
                    end
                end else begin
                    queue_code_word(s_tdata[CODE_W-1:0]);
                end
            end
            if (m_tvalid && m_tready) begin
                symbols_out++;
                if (symbol_q.size() == 0) begin
                    note_mismatch("unexpected word, symbol", m_tdata[3:0], -1);
                end else begin
                    e = symbol_q.pop_front();
                    if (m_tdata[3:0] != e.symbol) begin
                        note_mismatch("symbol", m_tdata[3:0], e.symbol);
                    end
                    if (m_tdata[7:4] != e.index) begin
                        note_mismatch("symbol_index", m_tdata[7:4], e.index);
                    end
                    if (m_tlast != e.last) begin
                        note_mismatch("tlast", m_tlast, e.last);
                    end
                end
            end
        end
    end

    // receiver: stall mode picked at random from four, one long hold-off mid-run
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && codes_in >= 120) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = 50;
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic offer_code(input logic [CODE_W-1:0] code, input logic zero_word);
        int gap;
        s_tvalid    <= 1'b1;
        s_tdata     <= {4'b0, code};
        s_zero_word <= zero_word;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            // hold valid when there is no gap, so it is not lowered and raised at once
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        logic [CODE_W-1:0] code;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        if (m_tvalid !== 1'b0) begin
            note_mismatch("tvalid after reset", m_tvalid, 0);
        end
        @(negedge i_clk);

        for (int n = 0; n < NUM_DIRECTED; n++) begin
            offer_code(DIRECTED[n][CODE_W-1:0], DIRECTED[n][CODE_W]);
        end

        for (int n = 0; n < RANDOM_CODES; n++) begin
            case ($urandom_range(0, 7))
                0: code = {$urandom_range(0, 1) ? 4'hf : 4'h0, 8'($urandom)};
                1: code = {8'($urandom), $urandom_range(0, 1) ? 4'hf : 4'h0};
                2: code = 12'(1 << $urandom_range(0, CODE_W - 1));
                default: code = 12'($urandom);
            endcase
            offer_code(code, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (symbol_q.size() != 0) begin
            @(posedge i_clk);
        end
        // watch for stray words past the last one
        repeat (40) @(posedge i_clk);

        $display("covered %0d codes (%0d directed), %0d symbols checked",
                 codes_in, NUM_DIRECTED, symbols_out);
        $display("bursty input, four stall modes, one %0d-cycle output hold-off",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("rs_gf16_id_encoder regression: pass");
        end else begin
            $display("rs_gf16_id_encoder regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/rsid_pkg.sv
src/rsid_cell.sv
src/rsid_serializer.sv
src/rs_gf16_id_encoder.sv
sim/rs_gf16_id_encoder_test.sv
